[design/hsbs_pkg.sv]
// Shared constants and types of the binomial smoother for accumulator images.
package hsbs_pkg;

    // Stream payload widths.
    localparam int IN_TDATA_W    = 32;
    localparam int VALUE_W       = 32;
    localparam int COORD_W       = 10;
    localparam int OUT_PAYLOAD_W = VALUE_W + 2 * COORD_W;
    localparam int OUT_TDATA_W   = ((OUT_PAYLOAD_W + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_INDEX_W-1:0] REG_AXIS         = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_WRAP_X       = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(3);

    // Pass direction.
    localparam logic AXIS_HORIZONTAL = 1'b0;
    localparam logic AXIS_VERTICAL   = 1'b1;

    // Results caused by one pixel.
    localparam int MAX_RESULTS = 3;
    localparam int COUNT_W     = 2;

    typedef logic [COUNT_W-1:0] t_count;

    typedef struct packed {
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
        logic [VALUE_W-1:0] value;
    } t_result;

    typedef struct packed {
        t_count                       count;
        t_result [MAX_RESULTS-1:0]    item;
    } t_result_set;

endpackage

[design/hsbs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module hsbs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read in the same cycle as a write to the same entry returns the old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/hsbs_emitter.sv]
// Output register that holds the results of one pixel and sends them one per transfer.
module hsbs_emitter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  hsbs_pkg::t_result_set           i_set,
    output logic                            o_free,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [hsbs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast
);

    import hsbs_pkg::*;

    logic        r_valid;
    t_count      r_idx;
    t_result_set r_set;
    t_result     cur;
    logic        on_last;
    logic        xfer;

    assign cur     = r_set.item[r_idx];
    assign on_last = (r_idx == (r_set.count - t_count'(1)));
    assign xfer    = r_valid && m_axis_tready;
    assign o_free  = !r_valid || (xfer && on_last);

    // Control: valid flag and position within the held set.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load && o_free) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (xfer) begin
            if (on_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + t_count'(1);
            end
        end
    end

    // Payload: the results of one pixel.
    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_set <= i_set;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({cur.y, cur.x, cur.value});
    assign m_axis_tlast  = on_last;

endmodule

[design/hough_space_binomial_smoother.sv]
// Top level of the 1-2-1 binomial smoother for Hough accumulator images.
//
// Pixels arrive in raster order on the s_axis channel, one per transfer. Each pixel
// causes zero to three results on the m_axis channel, each carrying the smoothed
// value and its column and row; tlast marks the last result caused by a pixel.
// The configuration channel writes pass direction, wrap mode, width and height;
// a write to one of these restarts the frame at pixel (0,0). Write it only while
// the block is idle. An accepted pixel passes the processing stage and then the
// output register before its first result is presented. Throughput is one pixel
// per cycle while the receiver is ready, set by the single read-modify-write of the
// line-store RAM (one entry per column, holding the rows one and two above); extra
// results at a horizontal row end or on the last row of a vertical pass hold the
// input back. When the receiver stalls, the output register holds its result and
// the input keeps accepting until the processing stage is also full.
// Reset is synchronous and active low: it empties the pipeline, selects a horizontal
// non-wrapping pass over a 1024 by 1024 image and restarts the frame. The line
// store needs no clearing pass, as each frame writes a row before reading it.
module hough_space_binomial_smoother #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration writes.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [hsbs_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [hsbs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Pixel input.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [hsbs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [31:0] pixel_value
    // Result output.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [31:0] out_value, [41:32] out_x, [51:42] out_y, [55:52] zero
    output logic [hsbs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tlast   // out_last
);

    import hsbs_pkg::*;

    localparam int P   = PIXEL_BITS;
    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int CWW = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
    localparam int CHW = (HW > CFG_DATA_W) ? HW : CFG_DATA_W;
    localparam int WIDTH_RST  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int HEIGHT_RST = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

    // Weighted sum (a + 2c + b) / 4, kept two bits wider so it never wraps.
    function automatic logic [P-1:0] smooth(input logic [P-1:0] a, input logic [P-1:0] c,
                                            input logic [P-1:0] b);
        logic [P+1:0] sum;
        sum = {1'b0, c, 1'b0} + {2'b00, a} + {2'b00, b};
        return sum[P+1:2];
    endfunction

    function automatic t_result make_result(input logic [P-1:0] v,
                                            input logic [COORD_W-1:0] x,
                                            input logic [COORD_W-1:0] y);
        t_result r;
        r.value = VALUE_W'(v);
        r.x     = x;
        r.y     = y;
        return r;
    endfunction

    // Configuration registers, sizes stored already clamped to their valid range.
    logic          r_axis;
    logic          r_wrap;
    logic [WW-1:0] r_width;
    logic [HW-1:0] r_height;
    logic [CWW-1:0] cfg_w_ext;
    logic [CHW-1:0] cfg_h_ext;
    logic [WW-1:0]  n_width;
    logic [HW-1:0]  n_height;
    logic           cfg_write;
    logic           cfg_known;

    // Frame position of the next pixel.
    logic [XW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic [XW:0]   x_inc;
    logic [YW:0]   y_inc;
    logic          x_end;
    logic          y_end;

    // Processing stage.
    logic          r_s1_valid;
    logic [P-1:0]  r_s1_pix;
    logic [XW-1:0] r_s1_x;
    logic [YW-1:0] r_s1_y;
    logic          r_s1_first;
    logic          r_s1_second;
    logic          r_s1_last;
    logic          r_s1_top;
    logic          r_s1_row1;
    logic          r_s1_bottom;

    // Horizontal window.
    logic [P-1:0] r_prev;
    logic [P-1:0] r_cur;
    logic [P-1:0] r_first;
    logic [P-1:0] r_second;

    // Line store and forwarding of a write that overlaps the next read.
    logic           ram_we;
    logic [2*P-1:0] ram_wdata;
    logic [2*P-1:0] ram_rdata;
    logic           r_fwd;
    logic [2*P-1:0] r_fwd_data;
    logic [2*P-1:0] line_rd;
    logic [P-1:0]   above;
    logic [P-1:0]   two_above;

    logic               accept;
    logic               s1_adv;
    logic               em_free;
    logic               short_axis;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    t_result_set        set;
    t_count             k;

    // Configuration write decode and size clamping.
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign cfg_w_ext   = CWW'(i_cfg_data);
    assign cfg_h_ext   = CHW'(i_cfg_data);

    always_comb begin
        if (cfg_w_ext == '0) begin
            n_width = WW'(1);
        end else if (cfg_w_ext > CWW'(MAX_WIDTH)) begin
            n_width = WW'(MAX_WIDTH);
        end else begin
            n_width = WW'(cfg_w_ext);
        end
        if (cfg_h_ext == '0) begin
            n_height = HW'(1);
        end else if (cfg_h_ext > CHW'(MAX_HEIGHT)) begin
            n_height = HW'(MAX_HEIGHT);
        end else begin
            n_height = HW'(cfg_h_ext);
        end
    end

    always_comb begin
        case (i_cfg_index)
            REG_AXIS, REG_WRAP_X, REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: cfg_known = 1'b1;
            default: cfg_known = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis   <= AXIS_HORIZONTAL;
            r_wrap   <= 1'b0;
            r_width  <= WW'(WIDTH_RST);
            r_height <= HW'(HEIGHT_RST);
        end else if (cfg_write) begin
            case (i_cfg_index)
                REG_AXIS:         r_axis   <= i_cfg_data[0];
                REG_WRAP_X:       r_wrap   <= i_cfg_data[0];
                REG_IMAGE_WIDTH:  r_width  <= n_width;
                REG_IMAGE_HEIGHT: r_height <= n_height;
                default: ;
            endcase
        end
    end

    // Handshake between input, processing stage and output register.
    assign s1_adv        = r_s1_valid && ((set.count == '0) || em_free);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Raster position counters; a known register write restarts the frame.
    assign x_inc = {1'b0, r_x} + (XW+1)'(1);
    assign y_inc = {1'b0, r_y} + (YW+1)'(1);
    assign x_end = (x_inc >= (XW+1)'(r_width));
    assign y_end = (y_inc >= (YW+1)'(r_height));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
        end else if (cfg_write && cfg_known) begin
            r_x <= '0;
            r_y <= '0;
        end else if (accept) begin
            if (x_end) begin
                r_x <= '0;
                r_y <= y_end ? '0 : y_inc[YW-1:0];
            end else begin
                r_x <= x_inc[XW-1:0];
            end
        end
    end

    // Processing stage valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_fwd      <= ram_we && (r_s1_x == r_x);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Processing stage payload, with the position flags worked out on entry.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix    <= s_axis_tdata[P-1:0];
            r_s1_x      <= r_x;
            r_s1_y      <= r_y;
            r_s1_first  <= (r_x == '0);
            r_s1_second <= (r_x == XW'(1));
            r_s1_last   <= x_end;
            r_s1_top    <= (r_y == '0);
            r_s1_row1   <= (r_y == YW'(1));
            r_s1_bottom <= y_end;
            r_fwd_data  <= ram_wdata;
        end
    end

    // Line store: each column entry holds {row two above, row above}.
    hsbs_ram #(
        .WIDTH (2 * P),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_x),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (r_x),
        .o_rdata (ram_rdata)
    );

    assign line_rd   = r_fwd ? r_fwd_data : ram_rdata;
    assign above     = r_s1_top ? '0 : line_rd[P-1:0];
    assign two_above = (r_s1_top || r_s1_row1) ? '0 : line_rd[2*P-1:P];
    assign ram_wdata = {above, r_s1_pix};
    assign short_axis = (r_axis == AXIS_HORIZONTAL) ? (r_width < WW'(3))
                                                    : (r_height < HW'(3));
    assign ram_we    = s1_adv && (r_axis == AXIS_VERTICAL) && !short_axis;

    // Horizontal window update as each pixel leaves the stage.
    always_ff @(posedge i_clk) begin
        if (s1_adv && (r_axis == AXIS_HORIZONTAL) && !short_axis) begin
            if (r_s1_first) begin
                r_first <= r_s1_pix;
            end
            if (r_s1_second) begin
                r_second <= r_s1_pix;
            end
            r_prev <= r_cur;
            r_cur  <= r_s1_pix;
        end
    end

    // Results of the pixel in the stage, in output order.
    assign cx = COORD_W'(r_s1_x);
    assign cy = COORD_W'(r_s1_y);

    always_comb begin
        set = '0;
        k   = '0;
        if (short_axis) begin
            set.item[k] = make_result(r_s1_pix, cx, cy);
            k = k + t_count'(1);
        end else if (r_axis == AXIS_HORIZONTAL) begin
            if (r_s1_first && !r_wrap) begin
                set.item[k] = make_result(r_s1_pix, cx, cy);
                k = k + t_count'(1);
            end
            if (!r_s1_first && !r_s1_second) begin
                set.item[k] = make_result(smooth(r_prev, r_cur, r_s1_pix),
                                          cx - COORD_W'(1), cy);
                k = k + t_count'(1);
            end
            if (r_s1_last) begin
                if (r_wrap) begin
                    set.item[k] = make_result(smooth(r_cur, r_s1_pix, r_first), cx, cy);
                    k = k + t_count'(1);
                    set.item[k] = make_result(smooth(r_s1_pix, r_first, r_second),
                                              '0, cy);
                    k = k + t_count'(1);
                end else begin
                    set.item[k] = make_result(r_s1_pix, cx, cy);
                    k = k + t_count'(1);
                end
            end
        end else begin
            if (!r_s1_top) begin
                set.item[k] = make_result(smooth(two_above, above, r_s1_pix),
                                          cx, cy - COORD_W'(1));
                k = k + t_count'(1);
            end
            if (r_s1_bottom) begin
                set.item[k] = make_result(smooth(above, r_s1_pix, '0), cx, cy);
                k = k + t_count'(1);
            end
        end
        set.count = k;
    end

    // Output register.
    hsbs_emitter u_emitter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (s1_adv && (set.count != '0)),
        .i_set         (set),
        .o_free        (em_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

[design/hsbs_checker.sv]
// Port-level checks of the smoother, bound to its top level.
module hsbs_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [hsbs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tlast
);

    import hsbs_pkg::*;

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A stalled result keeps its value and its last marker.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // The input only stalls behind a waiting result.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result waiting");

    // A pixel's results follow each other with no gap until the one marked last.
    a_set_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("results of one pixel broken off");

endmodule

bind hough_space_binomial_smoother hsbs_checker u_hsbs_checker (.*);

[verif/tb.sv]
// Self-checking testbench for the 1-2-1 binomial smoother of accumulator images.
`timescale 1ns / 1ps

module tb;
    import hsbs_pkg::*;

    localparam int MAX_W              = 1024;
    localparam int MAX_H              = 1024;
    localparam int DRAIN_CYCLES       = 8;
    localparam int LONG_HOLD_CYCLES   = 300;
    localparam int RANDOM_PIXELS      = 180;
    localparam int WIDE_ROW_PIXELS    = 48;
    localparam int TALL_COLUMN_PIXELS = 40;
    localparam int CYCLE_LIMIT        = 1000000;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } t_smoothed;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [31:0] pixel_value
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [31:0] out_value, [41:32] out_x, [51:42] out_y
    logic                   m_axis_tlast;   // out_last

    // Smoothed pixels still owed by the block, oldest first.
    t_smoothed pending_results[$];

    // Mirror of the block's configuration and frame state.
    logic        cfg_axis;
    logic        cfg_wrap;
    logic [10:0] cfg_width;
    logic [10:0] cfg_height;
    int unsigned col_pos;
    int unsigned row_pos;
    logic [31:0] left2_px;
    logic [31:0] left1_px;
    logic [31:0] row_first_px;
    logic [31:0] row_second_px;
    logic [31:0] line_above [MAX_W];
    logic [31:0] line_two_above [MAX_W];

    int  err_count;
    int  pixels_sent;
    int  cycle_count;
    bit  tx_gaps;
    bit  rx_gaps;
    bit  hold_req;

    hough_space_binomial_smoother dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock with a 4 ns period.
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Weighted sum 1-2-1 formed two bits wider, then divided by four.
    function automatic logic [31:0] binomial3(input logic [31:0] a, input logic [31:0] c,
                                              input logic [31:0] b);
        logic [33:0] sum;
        sum = {2'b00, a} + {2'b00, b} + {1'b0, c, 1'b0};
        return sum[33:2];
    endfunction

    // Size registers of zero act as one, oversize values saturate.
    function automatic int unsigned clamp_size(input logic [10:0] v, input int unsigned maxv);
        if (v == 11'd0) return 1;
        if (v > maxv) return maxv;
        return 32'(v);
    endfunction

    // Register write as seen by the frame state: a known index restarts the frame.
    function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_AXIS:         cfg_axis   = val[0];
            REG_WRAP_X:       cfg_wrap   = val[0];
            REG_IMAGE_WIDTH:  cfg_width  = val;
            REG_IMAGE_HEIGHT: cfg_height = val;
            default:          return;
        endcase
        col_pos = 0;
        row_pos = 0;
    endfunction

    // Work out the results one accepted pixel causes and queue them.
    function automatic void smooth_pixel(input logic [31:0] p);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        int          n;
        logic [31:0] above;
        logic [31:0] two_above;
        t_smoothed   res [MAX_RESULTS];
        w = clamp_size(cfg_width, MAX_W);
        h = clamp_size(cfg_height, MAX_H);
        x = col_pos;
        y = row_pos;
        n = 0;
        if (cfg_axis == AXIS_HORIZONTAL) begin
            if (w < 3) begin
                res[n] = '{p, x[9:0], y[9:0], 1'b0}; n++;
            end else begin
                if (x == 0) row_first_px = p;
                if (x == 1) row_second_px = p;
                if (x == 0 && !cfg_wrap) begin
                    res[n] = '{p, x[9:0], y[9:0], 1'b0}; n++;
                end
                if (x >= 2) begin
                    res[n] = '{binomial3(left2_px, left1_px, p), 10'(x - 1), y[9:0], 1'b0};
                    n++;
                end
                if (x + 1 == w) begin
                    if (cfg_wrap) begin
                        res[n] = '{binomial3(left1_px, p, row_first_px), x[9:0], y[9:0], 1'b0};
                        n++;
                        res[n] = '{binomial3(p, row_first_px, row_second_px), 10'd0, y[9:0],
                                   1'b0};
                        n++;
                    end else begin
                        res[n] = '{p, x[9:0], y[9:0], 1'b0}; n++;
                    end
                end
                left2_px = left1_px;
                left1_px = p;
            end
        end else begin
            if (h < 3) begin
                res[n] = '{p, x[9:0], y[9:0], 1'b0}; n++;
            end else begin
                above     = (y >= 1) ? line_above[x] : 32'd0;
                two_above = (y >= 2) ? line_two_above[x] : 32'd0;
                if (y >= 1) begin
                    res[n] = '{binomial3(two_above, above, p), x[9:0], 10'(y - 1), 1'b0}; n++;
                end
                if (y + 1 == h) begin
                    res[n] = '{binomial3(above, p, 32'd0), x[9:0], y[9:0], 1'b0}; n++;
                end
                line_two_above[x] = above;
                line_above[x]     = p;
            end
        end
        if (n > 0) res[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) pending_results.push_back(res[i]);
        col_pos = x + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = y + 1;
            if (row_pos >= h) row_pos = 0;
        end
    endfunction

    // Pixel values: full range, small counts, values near the top and the two extremes.
    function automatic logic [31:0] rand_pixel();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom_range(255);
            2:       return 32'hFFFF_FF00 | $urandom_range(255);
            default: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
        endcase
    endfunction

    // Offer one pixel and wait for its transfer; entered and left at a falling edge.
    task automatic send_pixel(input logic [31:0] v);
        while (tx_gaps && $urandom_range(99) < 32) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        smooth_pixel(v);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random_pixels(input int count);
        for (int i = 0; i < count; i++) send_pixel(rand_pixel());
    endtask

    // Drop valid, wait for every owed result, then let the pipeline settle.
    task automatic finish_pixels();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // One register write transfer; valid is left high for a following write.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(idx, val);
        @(negedge i_clk);
    endtask

    // Writes all four registers; the unused upper bits of the one-bit registers are random.
    task automatic set_config(input logic axis, input logic wrap, input logic [10:0] width,
                              input logic [10:0] height);
        write_reg(REG_AXIS, {10'($urandom), axis});
        write_reg(REG_WRAP_X, {10'($urandom), wrap});
        write_reg(REG_IMAGE_WIDTH, width);
        write_reg(REG_IMAGE_HEIGHT, height);
        i_cfg_valid <= 1'b0;
    endtask

    // Straight after reset: horizontal, no wrap, 1024 wide.
    task automatic test_reset_defaults();
        send_pixel(32'd0);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'd1);
        send_pixel(32'h8000_0000);
        finish_pixels();
    endtask

    // Shortest rows: three wide with and without wrap, then the pass-through widths.
    task automatic test_narrow_rows();
        set_config(AXIS_HORIZONTAL, 1'b0, 11'd3, 11'd2);
        repeat (3) send_pixel(32'hFFFF_FFFF);
        finish_pixels();
        set_config(AXIS_HORIZONTAL, 1'b1, 11'd3, 11'd2);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'd0);
        send_pixel(32'hFFFF_FFFE);
        finish_pixels();
        set_config(AXIS_HORIZONTAL, 1'b1, 11'd2, 11'd1);
        send_pixel(32'hDEAD_BEEF);
        send_pixel(32'd0);
        finish_pixels();
        set_config(AXIS_HORIZONTAL, 1'b0, 11'd0, 11'd0);
        send_pixel(32'hFFFF_FFFF);
        finish_pixels();
    endtask

    // Vertical pass: three rows with zero padding, then a two-row pass-through.
    task automatic test_short_columns();
        set_config(AXIS_VERTICAL, 1'b0, 11'd2, 11'd3);
        repeat (6) send_pixel(32'hFFFF_FFFF);
        finish_pixels();
        set_config(AXIS_VERTICAL, 1'b1, 11'd1, 11'd2);
        send_pixel(32'h1234_5678);
        send_pixel(32'hFFFF_FFFF);
        finish_pixels();
    endtask

    // Writes to unknown indices must not restart the row in progress.
    task automatic test_unknown_register();
        set_config(AXIS_HORIZONTAL, 1'b0, 11'd4, 11'd3);
        send_pixel(32'd7);
        send_pixel(32'd9);
        finish_pixels();
        write_reg(8'd255, 11'h7FF);
        write_reg(CFG_INDEX_W'($urandom_range(4, 254)), 11'($urandom));
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'd3);
        finish_pixels();
    endtask

    // Random small images, whole frames mostly, with some frames cut short.
    task automatic test_random_frames();
        int          start;
        int          phase;
        int unsigned w;
        int unsigned h;
        int          count;
        logic [10:0] wr;
        logic [10:0] hr;
        start = pixels_sent;
        phase = 0;
        while (pixels_sent - start < RANDOM_PIXELS) begin
            wr = 11'($urandom_range(9));
            hr = 11'($urandom_range(6));
            set_config(1'($urandom_range(1)), 1'($urandom_range(1)), wr, hr);
            w = clamp_size(wr, MAX_W);
            h = clamp_size(hr, MAX_H);
            count = $urandom_range(1, 2) * w * h;
            if ($urandom_range(3) == 0) count = $urandom_range(1, count);
            // Every fourth phase runs with no idling on either side.
            tx_gaps = (phase % 4 != 1);
            rx_gaps = (phase % 4 != 1);
            send_random_pixels(count);
            finish_pixels();
            phase++;
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    // Receiver holds off while the sender keeps offering, so the block backs up.
    task automatic test_long_output_stall();
        set_config(AXIS_HORIZONTAL, 1'b1, 11'd5, 11'd4);
        tx_gaps = 1'b0;
        @(posedge i_clk);
        hold_req = 1'b1;
        @(negedge i_clk);
        send_random_pixels(40);
        finish_pixels();
        tx_gaps = 1'b1;
    endtask

    // Sender stops mid-frame until the block has delivered everything, then resumes.
    task automatic test_sender_pause();
        set_config(AXIS_VERTICAL, 1'b0, 11'd4, 11'd5);
        send_random_pixels(10);
        finish_pixels();
        send_random_pixels(10);
        finish_pixels();
    endtask

    // Start of a row at the largest width, given by an oversize register value.
    task automatic test_widest_row();
        set_config(AXIS_HORIZONTAL, 1'b1, 11'h7FF, 11'd1);
        send_random_pixels(WIDE_ROW_PIXELS);
        finish_pixels();
    endtask

    // Top of a column of the largest height, width zero acting as one.
    task automatic test_tallest_column();
        set_config(AXIS_VERTICAL, 1'b0, 11'd0, 11'd1024);
        send_random_pixels(TALL_COLUMN_PIXELS);
        finish_pixels();
    endtask

    // Result sink: random back-pressure, plus one long hold when asked.
    initial begin : result_sink
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= !(rx_gaps && $urandom_range(99) < 32);
            end
        end
    end

    // Compare each result transfer with the oldest owed result.
    always @(posedge i_clk) begin
        t_result   got;
        t_smoothed want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[OUT_PAYLOAD_W-1:0]);
            if (pending_results.size() == 0) begin
                $error("result with none owed: value %0h x %0d y %0d", got.value, got.x, got.y);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.value !== want.value) begin
                    $error("out_value: expected %0h, got %0h", want.value, got.value);
                    err_count++;
                end
                if (got.x !== want.x) begin
                    $error("out_x: expected %0d, got %0d", want.x, got.x);
                    err_count++;
                end
                if (got.y !== want.y) begin
                    $error("out_y: expected %0d, got %0d", want.y, got.y);
                    err_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("out_last: expected %0b, got %0b", want.last, m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    // Test sequence.
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        err_count     = 0;
        pixels_sent   = 0;
        cycle_count   = 0;
        tx_gaps       = 1'b1;
        rx_gaps       = 1'b1;
        hold_req      = 1'b0;
        cfg_axis      = AXIS_HORIZONTAL;
        cfg_wrap      = 1'b0;
        cfg_width     = 11'd1024;
        cfg_height    = 11'd1024;
        col_pos       = 0;
        row_pos       = 0;
        left2_px      = '0;
        left1_px      = '0;
        row_first_px  = '0;
        row_second_px = '0;
        for (int i = 0; i < MAX_W; i++) begin
            line_above[i]     = '0;
            line_two_above[i] = '0;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_narrow_rows();
        test_short_columns();
        test_unknown_register();
        test_random_frames();
        test_long_output_stall();
        test_sender_pause();
        test_widest_row();
        test_tallest_column();

        finish_pixels();
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
